// ----- design/i2cseq_pkg.sv -----
// Shared types and constants for the I2C EEPROM access sequencer.
// Holds command, bus-operation, phase and register-index codes, and the beat structs.
// No dependencies.
package i2cseq_pkg;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_WRITE    = 3'd1,
    CMD_CUR_READ = 3'd2,
    CMD_WR_BYTE  = 3'd3,
    CMD_ACK      = 3'd4,
    CMD_RX       = 3'd5
  } cmd_e;

  // Bus operation codes carried on each result beat
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_START  = 3'd1,
    OP_TX     = 3'd2,
    OP_RXACK  = 3'd3,
    OP_RXNACK = 3'd4,
    OP_STOP   = 3'd5
  } op_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CTLW     = 4'd1,
    PH_CTLW_CUR = 4'd2,
    PH_ADDR_HI  = 4'd3,
    PH_ADDR_LO  = 4'd4,
    PH_CTLR     = 4'd5,
    PH_RX       = 4'd6,
    PH_WDATA    = 4'd7,
    PH_WTX      = 4'd8
  } phase_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEV_BASE   = 2'd0,
    CFG_WIDE_ADDR  = 2'd1,
    CFG_PAGE_LOG2  = 2'd2,
    CFG_POLL_LIMIT = 2'd3
  } cfg_idx_e;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned FifoDepth  = 4;

  typedef struct packed {
    logic [7:0]  device_control_base;
    logic        wide_address;
    logic [3:0]  page_size_log2;
    logic [31:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] mem_address;
    logic [16:0] byte_count;
    logic [7:0]  data_byte;
    logic        bus_ack;
  } item_t;

  typedef struct packed {
    op_e        bus_op;
    logic [7:0] bus_byte;
    logic       data_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       error_flag;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    phase_e phase;
    logic   poll_zero;
  } stat_t;

  // Build one result beat; the last-of-run mark is set later
  function automatic res_t mk_res(op_e op, logic [7:0] tx_byte, logic dreq,
                                  logic [7:0] rdata, logic rvalid, logic done,
                                  logic err);
    res_t r;
    r.bus_op       = op;
    r.bus_byte     = tx_byte;
    r.data_request = dreq;
    r.read_data    = rdata;
    r.read_valid   = rvalid;
    r.done_res     = done;
    r.error_flag   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

// ----- design/i2c_eeprom_access_sequencer_core.sv -----
// Top level of the I2C EEPROM access sequencer: stream ports, configuration registers
// and the result queue. Depends on i2cseq_pkg and i2cseq_ctrl.
//
// Accepts one input beat per clock while s_axis_tready is high (request, write byte or
// bus response) and turns it, in the same cycle, into zero to three result beats that
// enter a four-entry result queue; the first result can be taken on the next cycle.
// s_axis_tready is high whenever the queue has room for three results, so an item whose
// results fit is taken every cycle; the output side drains one result beat per cycle
// while m_axis_tready is high, which sets the sustained rate to one item per cycle for
// items that cause one result, and lower for items that cause more. Configuration
// writes are taken every cycle and should be made while the sequencer is idle.
module i2c_eeprom_access_sequencer_core #(
  parameter int unsigned ADDRESS_BITS  = 16,
  parameter int unsigned MAX_PAGE_LOG2 = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] mem_address, [32:16] byte_count, [40:33] data_byte, [41] bus_ack
  input  logic [47:0] s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] bus_byte, [8] data_request, [16:9] read_data, [17] read_valid,
  // [18] done_res, [19] error_flag
  output logic [23:0] m_axis_tdata,
  // [2:0] bus_op
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned Depth = i2cseq_pkg::FifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  i2cseq_pkg::cfg_t  cfg_q, cfg_d;
  i2cseq_pkg::item_t item;
  i2cseq_pkg::stat_t status;
  i2cseq_pkg::res_t [i2cseq_pkg::MaxResults-1:0] res;
  logic [1:0]        res_count;

  i2cseq_pkg::res_t  fifo_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              in_acc, out_acc;
  i2cseq_pkg::res_t  head;

  assign cfg_ready_o = 1'b1;

  // Update configuration registers on a write beat
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (i2cseq_pkg::cfg_idx_e'(cfg_index_i))
        i2cseq_pkg::CFG_DEV_BASE:   cfg_d.device_control_base = cfg_data_i[7:0];
        i2cseq_pkg::CFG_WIDE_ADDR:  cfg_d.wide_address        = cfg_data_i[0];
        i2cseq_pkg::CFG_PAGE_LOG2:  cfg_d.page_size_log2      = cfg_data_i[3:0];
        i2cseq_pkg::CFG_POLL_LIMIT: cfg_d.poll_limit          = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_control_base <= 8'd160;
      cfg_q.wide_address        <= 1'b1;
      cfg_q.page_size_log2      <= 4'd5;
      cfg_q.poll_limit          <= 32'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the input beat
  always_comb begin
    item.cmd         = s_axis_tuser;
    item.mem_address = s_axis_tdata[15:0];
    item.byte_count  = s_axis_tdata[32:16];
    item.data_byte   = s_axis_tdata[40:33];
    item.bus_ack     = s_axis_tdata[41];
  end

  assign s_axis_tready = (count_q <= CntW'(Depth - i2cseq_pkg::MaxResults));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  i2cseq_ctrl #(
    .ADDRESS_BITS  (ADDRESS_BITS),
    .MAX_PAGE_LOG2 (MAX_PAGE_LOG2)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .res_o       (res),
    .res_count_o (res_count),
    .status_o    (status)
  );

  // Result queue: push up to three beats, pop one
  assign m_axis_tvalid = (count_q != '0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign head          = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(res_count);
    rd_ptr_d = rd_ptr_q + PtrW'(out_acc);
    count_d  = count_q + CntW'(res_count) - CntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(i2cseq_pkg::MaxResults); k++) begin
      if (2'(k) < res_count) begin
        fifo_q[wr_ptr_q + PtrW'(k)] <= res[k];
      end
    end
  end

  // Pack the head beat
  assign m_axis_tuser = head.bus_op;
  assign m_axis_tlast = head.last_of_run;
  assign m_axis_tdata = {4'd0, head.error_flag, head.done_res, head.read_valid,
                         head.read_data, head.data_request, head.bus_byte};

  // Queue never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overfilled");

  // A request taken while busy causes no result
  a_busy_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && status.phase != i2cseq_pkg::PH_IDLE &&
     (item.cmd == i2cseq_pkg::CMD_READ || item.cmd == i2cseq_pkg::CMD_WRITE ||
      item.cmd == i2cseq_pkg::CMD_CUR_READ)) |-> res_count == 2'd0)
    else $error("request accepted while busy produced results");

  // Polling phases always have attempts left
  a_poll_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == i2cseq_pkg::PH_CTLW || status.phase == i2cseq_pkg::PH_CTLW_CUR)
    |-> !status.poll_zero)
    else $error("polling phase with no attempts left");

  // An item taken in idle that queues a start and a control byte leaves the sequencer polling
  a_ctl_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && status.phase == i2cseq_pkg::PH_IDLE && res_count == 2'd2)
    |=> (status.phase == i2cseq_pkg::PH_CTLW || status.phase == i2cseq_pkg::PH_CTLW_CUR))
    else $error("request started without entering a polling phase");

endmodule

// ----- design/i2cseq_ctrl.sv -----
// Sequencer state and next-state logic: turns one accepted beat into up to three results.
// Depends on i2cseq_pkg.
module i2cseq_ctrl #(
  parameter int unsigned ADDRESS_BITS  = 16,
  parameter int unsigned MAX_PAGE_LOG2 = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          accept_i,
  input  i2cseq_pkg::item_t                             item_i,
  input  i2cseq_pkg::cfg_t                              cfg_i,
  output i2cseq_pkg::res_t [i2cseq_pkg::MaxResults-1:0] res_o,
  output logic [1:0]                                    res_count_o,
  output i2cseq_pkg::stat_t                             status_o
);

  localparam int unsigned AW = ADDRESS_BITS;
  localparam int unsigned PW = MAX_PAGE_LOG2 + 1;

  i2cseq_pkg::phase_e phase_q, phase_d;
  logic [AW-1:0]      cursor_q, cursor_d;
  logic [16:0]        rem_q, rem_d;
  logic [31:0]        poll_q, poll_d;
  logic [PW-1:0]      page_q, page_d;
  logic               wr_q, wr_d;

  logic [AW-1:0]      addr_trunc, cursor_inc, pg_src;
  logic [15:0]        cur_ext, src_ext;
  logic [3:0]         lg;
  logic [PW-1:0]      pg_size, pg_fresh;
  logic [31:0]        poll_eff, poll_dec;
  logic [16:0]        rem_dec;
  logic [PW-1:0]      page_dec;
  logic [7:0]         ctl_wr, ctl_rd;
  i2cseq_pkg::res_t [i2cseq_pkg::MaxResults-1:0] res;
  logic [1:0]         n;

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2cseq_pkg::PH_IDLE;
      cursor_q <= '0;
      rem_q    <= '0;
      poll_q   <= '0;
      page_q   <= '0;
      wr_q     <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cursor_q <= cursor_d;
      rem_q    <= rem_d;
      poll_q   <= poll_d;
      page_q   <= page_d;
      wr_q     <= wr_d;
    end
  end

  // Derived values: page room from a start address, decrements, control bytes
  always_comb begin
    addr_trunc = item_i.mem_address[AW-1:0];
    cursor_inc = cursor_q + AW'(1);
    pg_src     = (phase_q == i2cseq_pkg::PH_IDLE) ? addr_trunc : cursor_inc;
    src_ext    = 16'(pg_src);
    cur_ext    = 16'(cursor_q);
    lg         = (cfg_i.page_size_log2 > 4'(MAX_PAGE_LOG2)) ? 4'(MAX_PAGE_LOG2)
                                                            : cfg_i.page_size_log2;
    pg_size    = PW'(1) << lg;
    pg_fresh   = pg_size - (src_ext[PW-1:0] & (pg_size - PW'(1)));
    poll_eff   = (cfg_i.poll_limit == 32'd0) ? 32'd1 : cfg_i.poll_limit;
    poll_dec   = poll_q - 32'(poll_q != 32'd0);
    rem_dec    = rem_q - 17'(rem_q != 17'd0);
    page_dec   = page_q - PW'(page_q != '0);
    ctl_wr     = cfg_i.device_control_base;
    ctl_rd     = cfg_i.device_control_base + 8'd1;
  end

  // Next state and result beats for the accepted item
  always_comb begin
    phase_d  = phase_q;
    cursor_d = cursor_q;
    rem_d    = rem_q;
    poll_d   = poll_q;
    page_d   = page_q;
    wr_d     = wr_q;
    n        = 2'd0;
    res      = '0;
    if (accept_i) begin
      case (phase_q)
        i2cseq_pkg::PH_IDLE: begin
          if (item_i.cmd == i2cseq_pkg::CMD_READ || item_i.cmd == i2cseq_pkg::CMD_WRITE) begin
            if (item_i.byte_count == 17'd0) begin
              res[0] = i2cseq_pkg::mk_res(i2cseq_pkg::OP_NONE, 8'd0, 1'b0, 8'd0, 1'b0,
                                          1'b1, 1'b0);
              n      = 2'd1;
            end else begin
              cursor_d = addr_trunc;
              rem_d    = item_i.byte_count;
              wr_d     = (item_i.cmd == i2cseq_pkg::CMD_WRITE);
              if (item_i.cmd == i2cseq_pkg::CMD_WRITE) begin
                page_d = pg_fresh;
              end
              poll_d  = poll_eff;
              phase_d = i2cseq_pkg::PH_CTLW;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0,
                                           1'b0, 1'b0);
              res[1]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, ctl_wr, 1'b0, 8'd0, 1'b0,
                                           1'b0, 1'b0);
              n       = 2'd2;
            end
          end else if (item_i.cmd == i2cseq_pkg::CMD_CUR_READ) begin
            rem_d   = 17'd1;
            wr_d    = 1'b0;
            poll_d  = poll_eff;
            phase_d = i2cseq_pkg::PH_CTLW_CUR;
            res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0,
                                         1'b0, 1'b0);
            res[1]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, ctl_wr, 1'b0, 8'd0, 1'b0,
                                         1'b0, 1'b0);
            n       = 2'd2;
          end
        end
        i2cseq_pkg::PH_CTLW, i2cseq_pkg::PH_CTLW_CUR: begin
          if (item_i.cmd == i2cseq_pkg::CMD_ACK) begin
            if (!item_i.bus_ack) begin
              // retry the control byte until the poll budget runs out
              poll_d = poll_dec;
              if (poll_dec == 32'd0) begin
                phase_d = i2cseq_pkg::PH_IDLE;
                res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0,
                                             1'b1, 1'b1);
                n       = 2'd1;
              end else begin
                res[0] = i2cseq_pkg::mk_res(i2cseq_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0,
                                            1'b0, 1'b0);
                res[1] = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, ctl_wr, 1'b0, 8'd0, 1'b0,
                                            1'b0, 1'b0);
                n      = 2'd2;
              end
            end else if (phase_q == i2cseq_pkg::PH_CTLW_CUR) begin
              phase_d = i2cseq_pkg::PH_CTLR;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0,
                                           1'b0, 1'b0);
              res[1]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, ctl_rd, 1'b0, 8'd0, 1'b0,
                                           1'b0, 1'b0);
              n       = 2'd2;
            end else if (cfg_i.wide_address) begin
              phase_d = i2cseq_pkg::PH_ADDR_HI;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, cur_ext[15:8], 1'b0, 8'd0,
                                           1'b0, 1'b0, 1'b0);
              n       = 2'd1;
            end else begin
              phase_d = i2cseq_pkg::PH_ADDR_LO;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, cur_ext[7:0], 1'b0, 8'd0,
                                           1'b0, 1'b0, 1'b0);
              n       = 2'd1;
            end
          end
        end
        i2cseq_pkg::PH_ADDR_HI: begin
          if (item_i.cmd == i2cseq_pkg::CMD_ACK) begin
            if (!item_i.bus_ack) begin
              phase_d = i2cseq_pkg::PH_IDLE;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0,
                                           1'b1, 1'b1);
            end else begin
              phase_d = i2cseq_pkg::PH_ADDR_LO;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, cur_ext[7:0], 1'b0, 8'd0,
                                           1'b0, 1'b0, 1'b0);
            end
            n = 2'd1;
          end
        end
        i2cseq_pkg::PH_ADDR_LO: begin
          if (item_i.cmd == i2cseq_pkg::CMD_ACK) begin
            if (!item_i.bus_ack) begin
              phase_d = i2cseq_pkg::PH_IDLE;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0,
                                           1'b1, 1'b1);
              n       = 2'd1;
            end else if (wr_q) begin
              phase_d = i2cseq_pkg::PH_WDATA;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_NONE, 8'd0, 1'b1, 8'd0, 1'b0,
                                           1'b0, 1'b0);
              n       = 2'd1;
            end else begin
              phase_d = i2cseq_pkg::PH_CTLR;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0,
                                           1'b0, 1'b0);
              res[1]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, ctl_rd, 1'b0, 8'd0, 1'b0,
                                           1'b0, 1'b0);
              n       = 2'd2;
            end
          end
        end
        i2cseq_pkg::PH_CTLR: begin
          if (item_i.cmd == i2cseq_pkg::CMD_ACK) begin
            if (!item_i.bus_ack) begin
              phase_d = i2cseq_pkg::PH_IDLE;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0,
                                           1'b1, 1'b1);
            end else begin
              phase_d = i2cseq_pkg::PH_RX;
              res[0]  = i2cseq_pkg::mk_res((rem_q > 17'd1) ? i2cseq_pkg::OP_RXACK
                                                           : i2cseq_pkg::OP_RXNACK,
                                           8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
            end
            n = 2'd1;
          end
        end
        i2cseq_pkg::PH_RX: begin
          if (item_i.cmd == i2cseq_pkg::CMD_RX) begin
            rem_d    = rem_dec;
            cursor_d = cursor_inc;
            if (rem_dec != 17'd0) begin
              res[0] = i2cseq_pkg::mk_res((rem_dec > 17'd1) ? i2cseq_pkg::OP_RXACK
                                                            : i2cseq_pkg::OP_RXNACK,
                                          8'd0, 1'b0, item_i.data_byte, 1'b1, 1'b0, 1'b0);
            end else begin
              phase_d = i2cseq_pkg::PH_IDLE;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, item_i.data_byte,
                                           1'b1, 1'b1, 1'b0);
            end
            n = 2'd1;
          end
        end
        i2cseq_pkg::PH_WDATA: begin
          if (item_i.cmd == i2cseq_pkg::CMD_WR_BYTE) begin
            phase_d = i2cseq_pkg::PH_WTX;
            res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, item_i.data_byte, 1'b0, 8'd0,
                                         1'b0, 1'b0, 1'b0);
            n       = 2'd1;
          end
        end
        i2cseq_pkg::PH_WTX: begin
          if (item_i.cmd == i2cseq_pkg::CMD_ACK) begin
            if (!item_i.bus_ack) begin
              phase_d = i2cseq_pkg::PH_IDLE;
              res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0,
                                           1'b1, 1'b1);
              n       = 2'd1;
            end else begin
              rem_d    = rem_dec;
              page_d   = page_dec;
              cursor_d = cursor_inc;
              if (rem_dec == 17'd0) begin
                phase_d = i2cseq_pkg::PH_IDLE;
                res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0,
                                             1'b1, 1'b0);
                n       = 2'd1;
              end else if (page_dec == '0) begin
                // page end: stop, then poll the device again for the next page
                page_d  = pg_fresh;
                poll_d  = poll_eff;
                phase_d = i2cseq_pkg::PH_CTLW;
                res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0,
                                             1'b0, 1'b0);
                res[1]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0,
                                             1'b0, 1'b0);
                res[2]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_TX, ctl_wr, 1'b0, 8'd0, 1'b0,
                                             1'b0, 1'b0);
                n       = 2'd3;
              end else begin
                phase_d = i2cseq_pkg::PH_WDATA;
                res[0]  = i2cseq_pkg::mk_res(i2cseq_pkg::OP_NONE, 8'd0, 1'b1, 8'd0, 1'b0,
                                             1'b0, 1'b0);
                n       = 2'd1;
              end
            end
          end
        end
        default: begin
          phase_d = i2cseq_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Mark the final beat of the run
  always_comb begin
    res_o = res;
    for (int k = 0; k < int'(i2cseq_pkg::MaxResults); k++) begin
      res_o[k].last_of_run = (2'(k + 1) == n);
    end
  end

  assign res_count_o        = n;
  assign status_o.phase     = phase_q;
  assign status_o.poll_zero = (poll_q == 32'd0);

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the I2C EEPROM access sequencer core: request, write-byte and
// bus-response beats go in, bus command beats come out and are checked against a predictor.
// Depends on i2cseq_pkg and i2c_eeprom_access_sequencer_core.
`timescale 1ns / 100ps

module tb_top;
  import i2cseq_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseItems    = 30;
  localparam int unsigned MaxPrinted    = 30;

  // Command codes outside the defined set
  localparam logic [2:0] CmdSpareLo = 3'd6;
  localparam logic [2:0] CmdSpareHi = 3'd7;

  // Results that can be read straight off the behaviour
  localparam res_t ZeroCountDone = '{OP_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam res_t ErrorStop     = '{OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
  localparam res_t DataAsk       = '{OP_NONE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam res_t WriteDone     = '{OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam res_t LastReadFf    = '{OP_STOP, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1};

  typedef struct {
    bit    is_cfg;
    item_t beat;
    cfg_t  regs;
    bit    typed;
    res_t  want;
  } plan_row_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  // Sequencer state and registers as predicted
  phase_e      seq_phase   = PH_IDLE;
  logic [15:0] addr_cursor = '0;
  logic [16:0] bytes_left  = '0;
  logic [31:0] polls_left  = '0;
  logic [8:0]  page_left   = '0;
  logic        writing     = 1'b0;
  logic [7:0]  ctl_base    = 8'd160;
  logic        wide_addr   = 1'b1;
  logic [3:0]  page_lg     = 4'd5;
  logic [31:0] poll_max    = 32'd1000;

  res_t        step_beats[$];
  res_t        pending_beats[$];

  int unsigned tx_idle_pct      = 27;
  int unsigned rx_idle_pct      = 58;
  int unsigned beats_in         = 0;
  int unsigned beats_productive = 0;
  int unsigned beats_predicted  = 0;
  int unsigned beats_checked    = 0;
  int unsigned error_endings    = 0;
  int unsigned mismatches       = 0;
  int unsigned quiet_cycles     = 0;

  i2c_eeprom_access_sequencer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  function automatic void put_beat(op_e op, logic [7:0] tx, logic dreq, logic [7:0] rd,
                                   logic rv, logic done, logic err);
    res_t r;
    r = '{op, tx, dreq, rd, rv, done, err, 1'b0};
    step_beats.push_back(r);
  endfunction

  // Start condition followed by the control byte; read adds one, wrapping in 8 bits
  function automatic void control_try(logic rd);
    logic [7:0] ctl;
    ctl = ctl_base + {7'd0, rd};
    put_beat(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    put_beat(OP_TX, ctl, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
  endfunction

  // Arm the acknowledge poll; a zero limit still allows one attempt
  function automatic void open_control_write(phase_e ph);
    polls_left = (poll_max != 0) ? poll_max : 32'd1;
    seq_phase  = ph;
    control_try(1'b0);
  endfunction

  // Bytes up to the next page boundary; page sizes clamp at 256
  function automatic void refresh_page_room();
    logic [3:0] lg;
    logic [8:0] size;
    lg        = (page_lg > 4'd8) ? 4'd8 : page_lg;
    size      = 9'd1 << lg;
    page_left = size - ({1'b0, addr_cursor[7:0]} & (size - 9'd1));
  endfunction

  // Acknowledge every read byte but the last
  function automatic void ask_receive(logic [7:0] rd, logic rv);
    seq_phase = PH_RX;
    put_beat((bytes_left > 17'd1) ? OP_RXACK : OP_RXNACK, 8'h00, 1'b0, rd, rv, 1'b0, 1'b0);
  endfunction

  function automatic void drop_request();
    seq_phase = PH_IDLE;
    put_beat(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
  endfunction

  // Advance the predicted sequencer by one input beat, leaving its results in step_beats
  function automatic void sequencer_step(item_t it);
    step_beats.delete();
    if (seq_phase == PH_IDLE) begin
      if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
        if (it.byte_count == 0) begin
          put_beat(OP_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
          addr_cursor = it.mem_address;
          bytes_left  = it.byte_count;
          writing     = (it.cmd == CMD_WRITE);
          if (writing) refresh_page_room();
          open_control_write(PH_CTLW);
        end
      end else if (it.cmd == CMD_CUR_READ) begin
        bytes_left = 17'd1;
        writing    = 1'b0;
        open_control_write(PH_CTLW_CUR);
      end
    end else if (it.cmd == CMD_ACK) begin
      case (seq_phase)
        PH_CTLW, PH_CTLW_CUR: begin
          if (!it.bus_ack) begin
            if (polls_left != 0) polls_left = polls_left - 32'd1;
            if (polls_left == 0) drop_request();
            else control_try(1'b0);
          end else if (seq_phase == PH_CTLW_CUR) begin
            seq_phase = PH_CTLR;
            control_try(1'b1);
          end else if (wide_addr) begin
            seq_phase = PH_ADDR_HI;
            put_beat(OP_TX, addr_cursor[15:8], 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          end else begin
            seq_phase = PH_ADDR_LO;
            put_beat(OP_TX, addr_cursor[7:0], 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          end
        end
        PH_ADDR_HI: begin
          if (!it.bus_ack) begin
            drop_request();
          end else begin
            seq_phase = PH_ADDR_LO;
            put_beat(OP_TX, addr_cursor[7:0], 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          end
        end
        PH_ADDR_LO: begin
          if (!it.bus_ack) begin
            drop_request();
          end else if (writing) begin
            seq_phase = PH_WDATA;
            put_beat(OP_NONE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
          end else begin
            seq_phase = PH_CTLR;
            control_try(1'b1);
          end
        end
        PH_CTLR: begin
          if (!it.bus_ack) drop_request();
          else ask_receive(8'h00, 1'b0);
        end
        PH_WTX: begin
          if (!it.bus_ack) begin
            drop_request();
          end else begin
            if (bytes_left != 0) bytes_left = bytes_left - 17'd1;
            if (page_left != 0) page_left = page_left - 9'd1;
            addr_cursor = addr_cursor + 16'd1;
            if (bytes_left == 0) begin
              seq_phase = PH_IDLE;
              put_beat(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
            end else if (page_left == 0) begin
              // close the page and poll for the next one
              put_beat(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
              refresh_page_room();
              open_control_write(PH_CTLW);
            end else begin
              seq_phase = PH_WDATA;
              put_beat(OP_NONE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
            end
          end
        end
        default: ;
      endcase
    end else if (it.cmd == CMD_RX && seq_phase == PH_RX) begin
      if (bytes_left != 0) bytes_left = bytes_left - 17'd1;
      addr_cursor = addr_cursor + 16'd1;
      if (bytes_left != 0) begin
        ask_receive(it.data_byte, 1'b1);
      end else begin
        seq_phase = PH_IDLE;
        put_beat(OP_STOP, 8'h00, 1'b0, it.data_byte, 1'b1, 1'b1, 1'b0);
      end
    end else if (it.cmd == CMD_WR_BYTE && seq_phase == PH_WDATA) begin
      seq_phase = PH_WTX;
      put_beat(OP_TX, it.data_byte, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    end
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  // New request: reads stay short so they always finish, writes are sometimes huge
  function automatic item_t random_request();
    item_t       it;
    int unsigned pick;
    it.mem_address = ($urandom_range(4) == 0) ? (16'hFFF0 | 16'($urandom_range(15)))
                                              : 16'($urandom);
    it.data_byte   = 8'($urandom);
    it.bus_ack     = 1'($urandom);
    pick           = $urandom_range(99);
    if (pick < 35) begin
      it.cmd        = CMD_READ;
      it.byte_count = 17'($urandom_range(1, 8));
    end else if (pick < 80) begin
      it.cmd        = CMD_WRITE;
      it.byte_count = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(1, 24));
    end else begin
      it.cmd        = CMD_CUR_READ;
      it.byte_count = 17'($urandom);
    end
    if (it.cmd != CMD_CUR_READ && $urandom_range(19) == 0) it.byte_count = '0;
    return it;
  endfunction

  // Next beat of a well-formed exchange; when closing, steer towards the idle phase
  function automatic item_t next_in_sequence(bit closing);
    item_t it;
    it.cmd         = CMD_ACK;
    it.mem_address = 16'($urandom);
    it.byte_count  = 17'($urandom);
    it.data_byte   = 8'($urandom);
    it.bus_ack     = 1'b1;
    // noise: no new request from idle, so no huge read can start
    if (!closing && $urandom_range(99) < 8) begin
      it.cmd     = (seq_phase == PH_IDLE) ? 3'($urandom_range(CMD_WR_BYTE, CmdSpareHi))
                                          : 3'($urandom);
      it.bus_ack = 1'($urandom);
      return it;
    end
    case (seq_phase)
      PH_IDLE:              it = random_request();
      PH_CTLW, PH_CTLW_CUR: it.bus_ack = closing || ($urandom_range(99) < 70);
      PH_RX:                it.cmd = CMD_RX;
      PH_WDATA:             it.cmd = CMD_WR_BYTE;
      default:              it.bus_ack = !closing && ($urandom_range(99) < 95);
    endcase
    return it;
  endfunction

  function automatic plan_row_t item_row(logic [2:0] cmd, logic [15:0] addr,
                                         logic [16:0] count, logic [7:0] data, logic ack,
                                         bit typed = 1'b0, res_t want = '0);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.beat   = '{cmd, addr, count, data, ack};
    r.regs   = '0;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_t regs);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.beat   = '0;
    r.regs   = regs;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  // Present one input beat, hold it until taken, then record what it should cause
  task automatic send_beat(input item_t it, input bit typed, input res_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.bus_ack, it.data_byte, it.byte_count, it.mem_address};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_in++;
    sequencer_step(it);
    if (step_beats.size() != 0) beats_productive++;
    if (typed) begin
      pending_beats.push_back(want);
      beats_predicted++;
    end else begin
      foreach (step_beats[k]) pending_beats.push_back(step_beats[k]);
      beats_predicted += step_beats.size();
    end
  endtask

  // Hold the input side until every predicted result has been taken
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (beats_checked < beats_predicted) @(posedge clk_i);
  endtask

  // Write all four registers, one beat each
  task automatic load_registers(input cfg_t regs);
    logic [31:0] value;
    cfg_idx_e    idx;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_DEV_BASE:  value = {24'd0, regs.device_control_base};
        CFG_WIDE_ADDR: value = {31'd0, regs.wide_address};
        CFG_PAGE_LOG2: value = {28'd0, regs.page_size_log2};
        default:       value = regs.poll_limit;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= value;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CFG_DEV_BASE:  ctl_base  = value[7:0];
        CFG_WIDE_ADDR: wide_addr = value[0];
        CFG_PAGE_LOG2: page_lg   = value[3:0];
        default:       poll_max  = value;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic close_request();
    while (seq_phase != PH_IDLE) send_beat(next_in_sequence(1'b1), 1'b0, '0);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = beats_productive;
    while (beats_productive - start < count) begin
      // now and then let the result side run dry before going on
      if ($urandom_range(99) < 3) wait_drain();
      send_beat(next_in_sequence(1'b0), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t ns: %s is %0h, predicted %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.bus_op       = op_e'(m_axis_tuser);
    got.bus_byte     = m_axis_tdata[7:0];
    got.data_request = m_axis_tdata[8];
    got.read_data    = m_axis_tdata[16:9];
    got.read_valid   = m_axis_tdata[17];
    got.done_res     = m_axis_tdata[18];
    got.error_flag   = m_axis_tdata[19];
    got.last_of_run  = m_axis_tlast;
    if (got.done_res && got.error_flag) error_endings++;
    if (pending_beats.size() == 0) begin
      report("result beat with nothing predicted, bus_op", got.bus_op, '0);
    end else begin
      want = pending_beats.pop_front();
      if (got.bus_op != want.bus_op) report("bus_op", got.bus_op, want.bus_op);
      if (got.bus_byte != want.bus_byte) report("bus_byte", got.bus_byte, want.bus_byte);
      if (got.data_request != want.data_request)
        report("data_request", got.data_request, want.data_request);
      if (got.read_data != want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.read_valid != want.read_valid)
        report("read_valid", got.read_valid, want.read_valid);
      if (got.done_res != want.done_res) report("done_res", got.done_res, want.done_res);
      if (got.error_flag != want.error_flag)
        report("error_flag", got.error_flag, want.error_flag);
      if (got.last_of_run != want.last_of_run)
        report("tlast", got.last_of_run, want.last_of_run);
      if (m_axis_tdata[23:20] != '0) report("tdata padding", m_axis_tdata[23:20], '0);
    end
  endtask

  // Take result beats, stalling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      beats_checked <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        beats_checked <= beats_checked + 1;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Give up when no beat has moved on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("no beat moved for %0d cycles", quiet_cycles);
        $display("i2c_eeprom_access_sequencer_core: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    plan_row_t plan[$];
    cfg_t      phase_regs[6];

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero count, ignored beats, a current-address read
    plan.push_back(item_row(CMD_READ, 16'h0000, 17'd0, 8'h00, 1'b0, 1'b1, ZeroCountDone));
    plan.push_back(item_row(CmdSpareLo, 16'hFFFF, 17'h1FFFF, 8'hFF, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd1, 8'h00, 1'b1));
    plan.push_back(item_row(CmdSpareHi, 16'h0000, 17'd0, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_CUR_READ, 16'h0000, 17'd0, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_RX, 16'h0000, 17'd0, 8'hFF, 1'b0, 1'b1, LastReadFf));
    // Top control byte, one address byte, one-byte pages: page split across address wrap
    plan.push_back(cfg_row('{8'hFF, 1'b0, 4'd0, 32'd1}));
    plan.push_back(item_row(CMD_WRITE, 16'hFFFF, 17'd2, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1, 1'b1, DataAsk));
    plan.push_back(item_row(CMD_WR_BYTE, 16'h0000, 17'd0, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1, 1'b1, DataAsk));
    plan.push_back(item_row(CMD_WR_BYTE, 16'h0000, 17'd0, 8'hFF, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1, 1'b1, WriteDone));
    // Single poll attempt runs out at the first no-acknowledge
    plan.push_back(item_row(CMD_WRITE, 16'h1234, 17'h1FFFF, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b0, 1'b1, ErrorStop));
    // Bottom control byte, two address bytes, largest poll limit
    plan.push_back(cfg_row('{8'h00, 1'b1, 4'd8, 32'hFFFF_FFFF}));
    plan.push_back(item_row(CMD_READ, 16'hA5C3, 17'h10000, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b0, 1'b1, ErrorStop));
    plan.push_back(item_row(CMD_WRITE, 16'h0000, 17'd1, 8'h00, 1'b0));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b1));
    plan.push_back(item_row(CMD_ACK, 16'h0000, 17'd0, 8'h00, 1'b0, 1'b1, ErrorStop));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drain();
        repeat (SettleCycles) @(posedge clk_i);
        load_registers(plan[i].regs);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // Register settings for the random phases
    phase_regs[0] = '{8'hA0, 1'b1, 4'd2, 32'd3};
    phase_regs[1] = '{8'hFE, 1'b0, 4'd0, 32'd1};
    phase_regs[2] = '{8'($urandom), 1'b1, 4'd15, 32'd0};
    phase_regs[3] = '{8'h55, 1'b0, 4'd3, 32'hFFFF_FFFF};
    phase_regs[4] = '{8'($urandom), 1'($urandom), 4'($urandom), 32'($urandom_range(1, 4))};
    phase_regs[5] = '{8'hA0, 1'b1, 4'd5, 32'd2};

    for (int p = 0; p < 6; p++) begin
      wait_drain();
      repeat (SettleCycles) @(posedge clk_i);
      load_registers(phase_regs[p]);
      // receiver-heavy gaps, then sender-heavy, then full rate
      case (p / 2)
        0: begin
          tx_idle_pct <= 27;
          rx_idle_pct <= 58;
        end
        1: begin
          tx_idle_pct <= 58;
          rx_idle_pct <= 27;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      run_random(PhaseItems);
      close_request();
    end

    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_beats.size() != 0)
      report("results never delivered, count", pending_beats.size(), '0);

    $display("Ran %0d input beats (%0d with results) over 9 register settings and three",
             beats_in, beats_productive);
    $display("stall mixes; %0d result beats compared, %0d requests ended in error, %0d faults",
             beats_checked, error_endings, mismatches);
    if (mismatches == 0) begin
      $display("i2c_eeprom_access_sequencer_core: match");
    end else begin
      $display("i2c_eeprom_access_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule
